>>> src/sbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbq_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 26;
  localparam int COEF_FRAC   = 23;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int GAIN_DIGITS = GAIN_W / 2;
  localparam int REG_IDX_W   = 3;

  // Five taps feed the distributed-arithmetic table: x, x1, x2, y1, y2.
  localparam int TAPS       = 5;
  localparam int TAP_IDX_W  = $clog2(TAPS);
  localparam int LUT_ADDR_W = TAPS;
  localparam int LUT_DEPTH  = 1 << TAPS;
  localparam int LUT_W      = COEF_W + 3;

  localparam int ACC_W  = LUT_W + SAMPLE_W;
  localparam int Y_Q_W  = ACC_W - COEF_FRAC;
  localparam int P2_W   = SAMPLE_W + 2;
  localparam int PROD_W = P2_W + GAIN_W;
  localparam int G_Q_W  = PROD_W - GAIN_FRAC;
  localparam int CNT_W  = $clog2(SAMPLE_W + 1);

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
  localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(3 << GAIN_FRAC);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FF0  = 3'd0,
    REG_FF1  = 3'd1,
    REG_FF2  = 3'd2,
    REG_FB1  = 3'd3,
    REG_FB2  = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic rotate;
    logic acc_en;
    logic acc_msb;
    logic round;
    logic triple;
    logic gain_en;
    logic finish;
  } chan_ctrl_t;

endpackage

`default_nettype wire

>>> src/sbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sbq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [DATA_W-1:0]        rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> src/sbq_lut.sv
`timescale 1ns / 1ps
`default_nettype none

module sbq_lut (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   wr_en,
  input  wire logic        [sbq_pkg::REG_IDX_W-1:0]   wr_index,
  input  wire logic        [sbq_pkg::COEF_W-1:0]      wr_data,
  input  wire logic        [sbq_pkg::LUT_ADDR_W-1:0]  raddr_l,
  input  wire logic        [sbq_pkg::LUT_ADDR_W-1:0]  raddr_r,
  output logic signed      [sbq_pkg::LUT_W-1:0]       rdata_l,
  output logic signed      [sbq_pkg::LUT_W-1:0]       rdata_r,
  output logic             [sbq_pkg::GAIN_W-1:0]      gain_eff,
  output logic                                        ready
);

  logic signed [sbq_pkg::COEF_W-1:0]     ff0, ff1, ff2, fb1, fb2;
  logic        [sbq_pkg::GAIN_W-1:0]     gain;
  logic                                  busy;
  logic        [sbq_pkg::LUT_ADDR_W-1:0] step;
  logic signed [sbq_pkg::LUT_W-1:0]      run_sum;
  logic signed [sbq_pkg::LUT_W-1:0]      run_sum_next;
  logic signed [sbq_pkg::LUT_W-1:0]      weight;
  logic signed [sbq_pkg::LUT_W-1:0]      stepped;
  logic        [sbq_pkg::LUT_ADDR_W-1:0] gray;
  logic        [sbq_pkg::TAP_IDX_W-1:0]  tz;
  logic                                  tz_found;
  logic                                  rebuild;

  assign rebuild = wr_en && (wr_index < sbq_pkg::REG_IDX_W'(sbq_pkg::REG_GAIN));
  assign ready   = !busy;
  assign gain_eff = (gain > sbq_pkg::GAIN_MAX) ? sbq_pkg::GAIN_MAX : gain;

  // The table is filled in Gray-code order, so each entry differs from the
  // previous one by a single tap weight and one adder is enough.
  assign gray = step ^ (step >> 1);

  always_comb begin
    tz       = '0;
    tz_found = 1'b0;
    for (int i = 0; i < sbq_pkg::TAPS; i++) begin
      if (!tz_found && step[i]) begin
        tz       = sbq_pkg::TAP_IDX_W'(i);
        tz_found = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (tz)
      sbq_pkg::TAP_IDX_W'(0): weight = sbq_pkg::LUT_W'(ff0);
      sbq_pkg::TAP_IDX_W'(1): weight = sbq_pkg::LUT_W'(ff1);
      sbq_pkg::TAP_IDX_W'(2): weight = sbq_pkg::LUT_W'(ff2);
      sbq_pkg::TAP_IDX_W'(3): weight = -sbq_pkg::LUT_W'(fb1);
      sbq_pkg::TAP_IDX_W'(4): weight = -sbq_pkg::LUT_W'(fb2);
      default:                weight = '0;
    endcase
  end

  assign stepped      = gray[tz] ? (run_sum + weight) : (run_sum - weight);
  assign run_sum_next = (step == '0) ? '0 : stepped;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff0  <= sbq_pkg::COEF_ONE;
      ff1  <= '0;
      ff2  <= '0;
      fb1  <= '0;
      fb2  <= '0;
      gain <= sbq_pkg::GAIN_ONE;
      busy <= 1'b1;
      step <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          sbq_pkg::REG_FF0:  ff0  <= wr_data;
          sbq_pkg::REG_FF1:  ff1  <= wr_data;
          sbq_pkg::REG_FF2:  ff2  <= wr_data;
          sbq_pkg::REG_FB1:  fb1  <= wr_data;
          sbq_pkg::REG_FB2:  fb2  <= wr_data;
          sbq_pkg::REG_GAIN: gain <= wr_data[sbq_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (rebuild) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == '1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      run_sum <= run_sum_next;
    end
  end

  sbq_ram #(
    .DATA_W (sbq_pkg::LUT_W),
    .DEPTH  (sbq_pkg::LUT_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (busy),
    .waddr   (gray),
    .wdata   (run_sum_next),
    .raddr_a (raddr_l),
    .rdata_a (rdata_l),
    .raddr_b (raddr_r),
    .rdata_b (rdata_r)
  );

  a_rebuild_after_write: assert property (@(posedge clk) disable iff (rst)
    rebuild |=> !ready)
    else $error("coefficient write did not restart the table fill");

endmodule

`default_nettype wire

>>> src/sbq_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module sbq_chan (
  input  wire logic                                  clk,
  input  wire sbq_pkg::chan_ctrl_t                   ctrl,
  input  wire logic signed [sbq_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic        [sbq_pkg::GAIN_W-1:0]     gain_eff,
  output logic             [sbq_pkg::LUT_ADDR_W-1:0] lut_addr,
  input  wire logic signed [sbq_pkg::LUT_W-1:0]      lut_data,
  output logic signed      [sbq_pkg::SAMPLE_W-1:0]   result
);

  localparam int W = sbq_pkg::SAMPLE_W;

  logic signed [W-1:0]                   x0, x1, x2, y1, y2;
  logic signed [sbq_pkg::LUT_W-1:0]      p;
  logic        [W-1:0]                   lo;
  logic signed [sbq_pkg::LUT_W:0]        term;
  logic signed [sbq_pkg::LUT_W:0]        s;
  logic signed [sbq_pkg::ACC_W-1:0]      full;
  logic signed [sbq_pkg::ACC_W-1:0]      full_rnd;
  logic signed [sbq_pkg::Y_Q_W-1:0]      yq;
  logic signed [W-1:0]                   y_sat;
  logic signed [W-1:0]                   y;
  logic signed [sbq_pkg::P2_W-1:0]       y3;
  logic signed [sbq_pkg::P2_W-1:0]       addend;
  logic        [sbq_pkg::GAIN_W-1:0]     gd;
  logic signed [sbq_pkg::P2_W-1:0]       p2;
  logic        [sbq_pkg::GAIN_W-1:0]     lo2;
  logic signed [sbq_pkg::P2_W:0]         s2;
  logic signed [sbq_pkg::PROD_W-1:0]     prod;
  logic signed [sbq_pkg::PROD_W-1:0]     prod_rnd;
  logic signed [sbq_pkg::G_Q_W-1:0]      gq;
  logic signed [W-1:0]                   g_sat;
  logic        [sbq_pkg::Y_Q_W-W:0]      yq_top;
  logic        [sbq_pkg::G_Q_W-W:0]      gq_top;

  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W - 1){1'b0}}};

  assign lut_addr = {y2[0], y1[0], x2[0], x1[0], x0[0]};

  // The sample bit of weight minus 2^(W-1) subtracts its table entry.
  assign term = ctrl.acc_msb ? -(sbq_pkg::LUT_W + 1)'(lut_data)
                             : (sbq_pkg::LUT_W + 1)'(lut_data);
  assign s    = (sbq_pkg::LUT_W + 1)'(p) + term;

  assign full     = {p, lo};
  assign full_rnd = full + sbq_pkg::ACC_W'(1 << (sbq_pkg::COEF_FRAC - 1));
  assign yq       = full_rnd[sbq_pkg::ACC_W-1:sbq_pkg::COEF_FRAC];
  assign yq_top   = yq[sbq_pkg::Y_Q_W-1:W-1];
  assign y_sat    = ((&yq_top) || !(|yq_top)) ? yq[W-1:0]
                  : (yq[sbq_pkg::Y_Q_W-1] ? SAT_MIN : SAT_MAX);

  always_comb begin
    unique case (gd[1:0])
      2'd0: addend = '0;
      2'd1: addend = sbq_pkg::P2_W'(y);
      2'd2: addend = sbq_pkg::P2_W'(y) <<< 1;
      2'd3: addend = y3;
    endcase
  end

  assign s2 = (sbq_pkg::P2_W + 1)'(p2) + (sbq_pkg::P2_W + 1)'(addend);

  assign prod     = {p2, lo2};
  assign prod_rnd = prod + sbq_pkg::PROD_W'(1 << (sbq_pkg::GAIN_FRAC - 1));
  assign gq       = prod_rnd[sbq_pkg::PROD_W-1:sbq_pkg::GAIN_FRAC];
  assign gq_top   = gq[sbq_pkg::G_Q_W-1:W-1];
  assign g_sat    = ((&gq_top) || !(|gq_top)) ? gq[W-1:0]
                  : (gq[sbq_pkg::G_Q_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x0 <= sample;
      if (ctrl.prime) begin
        x1 <= sample;
        x2 <= sample;
        y1 <= sample;
        y2 <= sample;
      end
    end else if (ctrl.rotate) begin
      x0 <= {x0[0], x0[W-1:1]};
      x1 <= {x1[0], x1[W-1:1]};
      x2 <= {x2[0], x2[W-1:1]};
      y1 <= {y1[0], y1[W-1:1]};
      y2 <= {y2[0], y2[W-1:1]};
    end else if (ctrl.round) begin
      x1 <= x0;
      x2 <= x1;
      y1 <= y_sat;
      y2 <= y1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p <= '0;
    end else if (ctrl.acc_en) begin
      p  <= s[sbq_pkg::LUT_W:1];
      lo <= {s[0], lo[W-1:1]};
    end
    if (ctrl.round) begin
      y <= y_sat;
    end
    if (ctrl.triple) begin
      y3 <= sbq_pkg::P2_W'(y) + (sbq_pkg::P2_W'(y) <<< 1);
      gd <= gain_eff;
      p2 <= '0;
    end else if (ctrl.gain_en) begin
      p2  <= sbq_pkg::P2_W'($signed(s2[sbq_pkg::P2_W:2]));
      lo2 <= {s2[1:0], lo2[sbq_pkg::GAIN_W-1:2]};
      gd  <= gd >> 2;
    end
    if (ctrl.finish) begin
      result <= g_sat;
    end
  end

endmodule

`default_nettype wire

>>> src/stereo_biquad_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// out_valid rises once an input beat has gone through the bit-serial steps over the
// coefficient sum table, the round and triple steps, the two-bit gain multiply digits
// and the finish step, if the output register is free. Beats are taken only in idle.
// Reset clears the priming flag and out_valid; ff0 and gain go to one, the rest to zero.
// After reset and after each coefficient write, a pass over every table entry fills the sum
// table and in_ready stays low until it ends.

module stereo_biquad_filter_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic        [sbq_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic        [sbq_pkg::COEF_W-1:0]    wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sbq_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic signed [sbq_pkg::SAMPLE_W-1:0] right_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [sbq_pkg::SAMPLE_W-1:0] left_out,
  output logic signed      [sbq_pkg::SAMPLE_W-1:0] right_out
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND,
    ST_TRIPLE,
    ST_GAIN,
    ST_FINISH
  } state_t;

  state_t                               state;
  logic        [sbq_pkg::CNT_W-1:0]     cnt;
  logic                                 primed;
  logic                                 accept;
  logic                                 finish_go;
  logic                                 lut_ready;
  logic        [sbq_pkg::GAIN_W-1:0]    gain_eff;
  logic        [sbq_pkg::LUT_ADDR_W-1:0] addr_l, addr_r;
  logic signed [sbq_pkg::LUT_W-1:0]     data_l, data_r;
  sbq_pkg::chan_ctrl_t                  ctrl;

  assign in_ready  = (state == ST_IDLE) && lut_ready && !wr_en;
  assign accept    = in_valid && in_ready;
  assign finish_go = (state == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    ctrl.load    = accept;
    ctrl.prime   = accept && !primed;
    ctrl.rotate  = (state == ST_RUN) && (cnt != sbq_pkg::CNT_W'(sbq_pkg::SAMPLE_W));
    ctrl.acc_en  = (state == ST_RUN) && (cnt != '0);
    ctrl.acc_msb = (state == ST_RUN) && (cnt == sbq_pkg::CNT_W'(sbq_pkg::SAMPLE_W));
    ctrl.round   = (state == ST_ROUND);
    ctrl.triple  = (state == ST_TRIPLE);
    ctrl.gain_en = (state == ST_GAIN);
    ctrl.finish  = finish_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state  <= ST_RUN;
            cnt    <= '0;
            primed <= 1'b1;
          end
        end
        ST_RUN: begin
          if (cnt == sbq_pkg::CNT_W'(sbq_pkg::SAMPLE_W)) begin
            state <= ST_ROUND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROUND: begin
          state <= ST_TRIPLE;
        end
        ST_TRIPLE: begin
          state <= ST_GAIN;
          cnt   <= '0;
        end
        ST_GAIN: begin
          if (cnt == sbq_pkg::CNT_W'(sbq_pkg::GAIN_DIGITS - 1)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  sbq_lut u_lut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .raddr_l  (addr_l),
    .raddr_r  (addr_r),
    .rdata_l  (data_l),
    .rdata_r  (data_r),
    .gain_eff (gain_eff),
    .ready    (lut_ready)
  );

  sbq_chan u_left (
    .clk      (clk),
    .ctrl     (ctrl),
    .sample   (left_sample),
    .gain_eff (gain_eff),
    .lut_addr (addr_l),
    .lut_data (data_l),
    .result   (left_out)
  );

  sbq_chan u_right (
    .clk      (clk),
    .ctrl     (ctrl),
    .sample   (right_sample),
    .gain_eff (gain_eff),
    .lut_addr (addr_r),
    .lut_data (data_r),
    .result   (right_out)
  );

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (cnt == '0))
    else $error("accepted beat did not start the bit-serial pass");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> out_valid)
    else $error("finished result was not presented");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("out_valid rose outside the finish step");

endmodule

`default_nettype wire

>>> tb/stereo_biquad_filter_top_tb.sv
`timescale 1ns / 1ps

module stereo_biquad_filter_top_tb;

  typedef logic signed [sbq_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [sbq_pkg::COEF_W-1:0] coef_t;

  localparam sample_t SAMPLE_HI = {1'b0, {(sbq_pkg::SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_LO = {1'b1, {(sbq_pkg::SAMPLE_W-1){1'b0}}};
  localparam coef_t COEF_HI = {1'b0, {(sbq_pkg::COEF_W-1){1'b1}}};
  localparam coef_t COEF_LO = {1'b1, {(sbq_pkg::COEF_W-1){1'b0}}};
  localparam logic [sbq_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sbq_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PHASES = 12;
  localparam int BEATS_PER_PHASE = 54;
  localparam int LATENCY_WAIT = 40;
  localparam int CYCLE_LIMIT = 600000;

  class biquad_scoreboard;
    longint ff0, ff1, ff2, fb1, fb2, gain;
    longint in_taps[2][2];
    longint out_taps[2][2];
    bit primed;
    sample_t expected_left[$];
    sample_t expected_right[$];

    function new();
      ff0 = longint'(1) <<< sbq_pkg::COEF_FRAC;
      ff1 = 0;
      ff2 = 0;
      fb1 = 0;
      fb2 = 0;
      gain = longint'(1) <<< sbq_pkg::GAIN_FRAC;
      in_taps = '{'{0, 0}, '{0, 0}};
      out_taps = '{'{0, 0}, '{0, 0}};
      primed = 1'b0;
    endfunction

    function void write_register(logic [sbq_pkg::REG_IDX_W-1:0] idx, coef_t data);
      longint c;
      c = longint'(signed'(data));
      case (idx)
        sbq_pkg::REG_FF0:  ff0 = c;
        sbq_pkg::REG_FF1:  ff1 = c;
        sbq_pkg::REG_FF2:  ff2 = c;
        sbq_pkg::REG_FB1:  fb1 = c;
        sbq_pkg::REG_FB2:  fb2 = c;
        sbq_pkg::REG_GAIN: gain = longint'(data[sbq_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_sample(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (sbq_pkg::SAMPLE_W - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function sample_t filter_sample(int ch, longint x);
      longint acc;
      longint y;
      longint g;
      longint gmax;
      longint geff;
      gmax = longint'(sbq_pkg::GAIN_MAX);
      geff = (gain > gmax) ? gmax : gain;
      acc = ff0 * x + ff1 * in_taps[ch][0] + ff2 * in_taps[ch][1]
          - fb1 * out_taps[ch][0] - fb2 * out_taps[ch][1];
      y = clamp_sample((acc + (longint'(1) <<< (sbq_pkg::COEF_FRAC - 1)))
                       >>> sbq_pkg::COEF_FRAC);
      g = clamp_sample((y * geff + (longint'(1) <<< (sbq_pkg::GAIN_FRAC - 1)))
                       >>> sbq_pkg::GAIN_FRAC);
      in_taps[ch][1] = in_taps[ch][0];
      in_taps[ch][0] = x;
      out_taps[ch][1] = out_taps[ch][0];
      out_taps[ch][0] = y;
      return sample_t'(g);
    endfunction

    function void note_input(sample_t l, sample_t r);
      longint xs[2];
      xs[0] = longint'(l);
      xs[1] = longint'(r);
      if (!primed) begin
        for (int ch = 0; ch < 2; ch++) begin
          in_taps[ch][0] = xs[ch];
          in_taps[ch][1] = xs[ch];
          out_taps[ch][0] = xs[ch];
          out_taps[ch][1] = xs[ch];
        end
        primed = 1'b1;
      end
      expected_left.push_back(filter_sample(0, xs[0]));
      expected_right.push_back(filter_sample(1, xs[1]));
    endfunction

    function int pending();
      return expected_left.size();
    endfunction

    function bit check_result(sample_t l, sample_t r, output string msg);
      sample_t el;
      sample_t er;
      msg = "";
      if (expected_left.size() == 0) begin
        msg = $sformatf("output beat with nothing expected: L=%0d R=%0d", l, r);
        return 1'b0;
      end
      el = expected_left.pop_front();
      er = expected_right.pop_front();
      if (l !== el || r !== er) begin
        msg = $sformatf("output beat: L=%0d (want %0d) R=%0d (want %0d)", l, el, r, er);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [sbq_pkg::REG_IDX_W-1:0] wr_index = '0;
  coef_t wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t left_sample = '0;
  sample_t right_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t left_out;
  sample_t right_out;

  biquad_scoreboard sb;
  int mismatches = 0;
  int cycles = 0;
  int sender_idle_pct = 23;
  int receiver_stall_pct = 45;

  stereo_biquad_filter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      if (!sb.check_result(left_out, right_out, msg)) begin
        report_mismatch(msg);
      end
    end
  end

  task automatic write_register(input logic [sbq_pkg::REG_IDX_W-1:0] idx,
                                input coef_t data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic send_pair(input sample_t l, input sample_t r);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_input(l, r);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_outputs();
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_HI;
      1: return SAMPLE_LO;
      2, 3: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t coef_within(int span);
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic load_settings(input int phase);
    coef_t c[5];
    logic [sbq_pkg::GAIN_W-1:0] g;
    case (phase)
      0: begin
        c = '{COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI};
        g = sbq_pkg::GAIN_MAX;
      end
      1: begin
        c = '{COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO};
        g = '0;
      end
      2: begin
        foreach (c[i]) c[i] = coef_t'($urandom);
        g = '1;
      end
      default: begin
        if (phase % 2 == 1) begin
          foreach (c[i]) c[i] = coef_t'($urandom);
          g = sbq_pkg::GAIN_W'($urandom);
        end else begin
          c[0] = coef_within(1 << 23);
          c[1] = coef_within(1 << 23);
          c[2] = coef_within(1 << 23);
          c[3] = coef_within(1 << 24);
          c[4] = coef_within(1 << 23);
          g = sbq_pkg::GAIN_W'($urandom_range(0, int'(sbq_pkg::GAIN_MAX)));
        end
      end
    endcase
    write_register(sbq_pkg::REG_FF0, c[0]);
    write_register(sbq_pkg::REG_FF1, c[1]);
    write_register(sbq_pkg::REG_FF2, c[2]);
    write_register(sbq_pkg::REG_FB1, c[3]);
    write_register(sbq_pkg::REG_FB2, c[4]);
    write_register(sbq_pkg::REG_GAIN, {10'($urandom), g});
    if (phase == 3) begin
      write_register(REG_SPARE_LO, coef_t'($urandom));
      write_register(REG_SPARE_HI, coef_t'($urandom));
    end
    wr_en <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Leave b0 and gain at their reset values so the defaults are checked,
    // while nonzero b1 and a2 make the history priming visible.
    write_register(sbq_pkg::REG_FF1, coef_t'(-(1 << 22)));
    write_register(sbq_pkg::REG_FB2, coef_t'(1 << 21));
    wr_en <= 1'b0;

    send_pair(SAMPLE_HI, SAMPLE_LO);
    send_pair('0, '0);
    send_pair(SAMPLE_LO, SAMPLE_HI);
    send_pair(-1, 1);
    send_pair(1, -1);
    send_pair(SAMPLE_HI, SAMPLE_HI);
    send_pair(SAMPLE_HI, SAMPLE_HI);
    send_pair(SAMPLE_LO, SAMPLE_LO);
    send_pair(SAMPLE_LO, SAMPLE_LO);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'hAAAAAA, 24'h555555);
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair('0, '0);
    for (int n = 0; n < 6; n++) begin
      send_pair(random_sample(), random_sample());
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      sender_idle_pct = (phase < 4) ? 23 : ((phase < 8) ? 45 : 0);
      receiver_stall_pct = (phase < 4) ? 45 : ((phase < 8) ? 23 : 0);
      load_settings(phase);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (n == BEATS_PER_PHASE / 2 && phase % 4 == 1) begin
          drain_outputs();
        end
        send_pair(random_sample(), random_sample());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sbq_pkg.sv
src/sbq_ram.sv
src/sbq_lut.sv
src/sbq_chan.sv
src/stereo_biquad_filter_top.sv
tb/stereo_biquad_filter_top_tb.sv
